// ===== hdl/rsfi_pkg.sv =====
// Shared types and constants for the RGBA step fade interpolation core.
// No dependencies; imported by every module of the core.
package rsfi_pkg;

  localparam int ChanW      = 8;
  localparam int NumLanes   = 4;
  localparam int ColorW     = ChanW * NumLanes;
  localparam int StepFieldW = 16;
  localparam int QuotBits   = ChanW;
  localparam int LaneLat    = QuotBits + 1;
  localparam int OutLat     = LaneLat + 2;

  localparam int AddrW    = 3;
  localparam int DataW    = 32;
  localparam int RegIdxW  = 1;

  localparam logic [RegIdxW-1:0]    RegFadeSteps   = 1'b0;
  localparam logic [StepFieldW-1:0] FadeStepsReset = 16'd256;

  typedef enum logic [1:0] {
    ModeFrom,
    ModeTo,
    ModeBlend
  } mode_e;

  typedef struct packed {
    logic              valid;
    mode_e             mode;
    logic [ColorW-1:0] color_from;
    logic [ColorW-1:0] color_to;
  } ctrl_t;

endpackage

// ===== hdl/rsfi_lane.sv =====
// One channel lane: weighted sum of two 8-bit channel values, then a
// pipelined restoring divider that retires one quotient bit per stage.
// Depends on rsfi_pkg.
module rsfi_lane
  import rsfi_pkg::*;
#(
  parameter int CntW = 16
) (
  input  logic             clk_i,
  input  logic [ChanW-1:0] from_chan_i,
  input  logic [ChanW-1:0] to_chan_i,
  input  logic [CntW-1:0]  wgt_from_i,
  input  logic [CntW-1:0]  cnt_i,
  input  logic [CntW-1:0]  len_i,
  output logic [ChanW-1:0] quot_o
);

  localparam int AccW = ChanW + CntW;

  logic [AccW-1:0]  prod_from_d;
  logic [AccW-1:0]  prod_to_d;
  logic [AccW-1:0]  rem_q  [QuotBits+1];
  logic [CntW-1:0]  len_q  [QuotBits+1];
  logic [ChanW-1:0] quot_q [QuotBits+1];

  assign prod_from_d = AccW'(from_chan_i) * AccW'(wgt_from_i);
  assign prod_to_d   = AccW'(to_chan_i) * AccW'(cnt_i);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= prod_from_d + prod_to_d;
    len_q[0]  <= len_i;
    quot_q[0] <= '0;
  end

  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    localparam int Shift = QuotBits - 1 - j;
    logic [AccW-1:0] dvs_d;
    logic            ge_d;

    assign dvs_d = AccW'(len_q[j]) << Shift;
    assign ge_d  = (rem_q[j] >= dvs_d);

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= ge_d ? (rem_q[j] - dvs_d) : rem_q[j];
      len_q[j+1]  <= len_q[j];
      quot_q[j+1] <= {quot_q[j][ChanW-2:0], ge_d};
    end
  end

  assign quot_o = quot_q[QuotBits];

endmodule

// ===== hdl/rsfi_merge.sv =====
// Merge stage: selects start color, end color or the lane quotients and
// packs the channels R,G,B,A into the registered result. Depends on rsfi_pkg.
module rsfi_merge
  import rsfi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic [ChanW-1:0]  quot_i [NumLanes],
  output logic              done_o,
  output logic [ColorW-1:0] color_out_o
);

  logic [ColorW-1:0] packed_d;
  logic [ColorW-1:0] color_d;
  logic [ColorW-1:0] color_q;
  logic              done_q;

  always_comb begin
    packed_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      packed_d[(NumLanes-1-i)*ChanW +: ChanW] = quot_i[i];
    end
  end

  always_comb begin
    unique case (ctrl_i.mode)
      ModeFrom:  color_d = ctrl_i.color_from;
      ModeTo:    color_d = ctrl_i.color_to;
      ModeBlend: color_d = packed_d;
      default:   color_d = ctrl_i.color_to;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign done_o      = done_q;
  assign color_out_o = color_q;

endmodule

// ===== hdl/rgba_step_fade_interpolation_core.sv =====
// Top level of the RGBA step fade interpolation core: APB fade length register,
// input register, four channel lanes and the merge stage. Depends on rsfi_pkg.
// The done_o strobe for a transfer at start passes the input register, the lane pipeline and the merge register.
// Throughput: one item per cycle; busy stays low, the divider is fully pipelined.
// Reset: fade_steps returns to 256 and all in-flight items are dropped.
module rgba_step_fade_interpolation_core
  import rsfi_pkg::*;
#(
  parameter int STEP_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ColorW-1:0]     color_from_i,
  input  logic [ColorW-1:0]     color_to_i,
  input  logic [StepFieldW-1:0] step_count_i,
  output logic                  done_o,
  output logic [ColorW-1:0]     color_out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam int CntW = (STEP_WIDTH < StepFieldW) ? STEP_WIDTH : StepFieldW;

  logic [StepFieldW-1:0] fade_steps_q;
  logic [RegIdxW-1:0]    reg_idx;
  logic                  cfg_wr;

  logic                  accept;
  logic [CntW-1:0]       cnt_m;
  logic [CntW-1:0]       len_m;
  mode_e                 mode_d;

  logic [ColorW-1:0]     from_q;
  logic [ColorW-1:0]     to_q;
  logic [CntW-1:0]       cnt_q;
  logic [CntW-1:0]       len_q;
  logic [CntW-1:0]       wgt_q;
  mode_e                 mode_q [LaneLat+1];
  logic [ColorW-1:0]     from_pipe_q [LaneLat+1];
  logic [ColorW-1:0]     to_pipe_q [LaneLat+1];
  logic                  vld_q [LaneLat+1];

  logic [ChanW-1:0]      quot [NumLanes];
  ctrl_t                 merge_ctrl;

  assign reg_idx = paddr[AddrW-1:AddrW-RegIdxW];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegFadeSteps) ? DataW'(fade_steps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q <= FadeStepsReset;
    end else if (cfg_wr && (reg_idx == RegFadeSteps)) begin
      fade_steps_q <= pwdata[StepFieldW-1:0];
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cnt_m  = step_count_i[CntW-1:0];
  assign len_m  = fade_steps_q[CntW-1:0];

  always_comb begin
    priority if (cnt_m == '0) begin
      mode_d = ModeFrom;
    end else if (cnt_m >= len_m) begin
      mode_d = ModeTo;
    end else begin
      mode_d = ModeBlend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LaneLat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i <= LaneLat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    from_q         <= color_from_i;
    to_q           <= color_to_i;
    cnt_q          <= cnt_m;
    len_q          <= len_m;
    wgt_q          <= len_m - cnt_m;
    mode_q[0]      <= mode_d;
    from_pipe_q[0] <= color_from_i;
    to_pipe_q[0]   <= color_to_i;
    for (int i = 1; i <= LaneLat; i++) begin
      mode_q[i]      <= mode_q[i-1];
      from_pipe_q[i] <= from_pipe_q[i-1];
      to_pipe_q[i]   <= to_pipe_q[i-1];
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam int Lsb = (NumLanes - 1 - l) * ChanW;
    rsfi_lane #(
      .CntW(CntW)
    ) u_lane (
      .clk_i      (clk_i),
      .from_chan_i(from_q[Lsb +: ChanW]),
      .to_chan_i  (to_q[Lsb +: ChanW]),
      .wgt_from_i (wgt_q),
      .cnt_i      (cnt_q),
      .len_i      (len_q),
      .quot_o     (quot[l])
    );
  end

  assign merge_ctrl.valid      = vld_q[LaneLat];
  assign merge_ctrl.mode       = mode_q[LaneLat];
  assign merge_ctrl.color_from = from_pipe_q[LaneLat];
  assign merge_ctrl.color_to   = to_pipe_q[LaneLat];

  rsfi_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (merge_ctrl),
    .quot_i     (quot),
    .done_o     (done_o),
    .color_out_o(color_out_o)
  );

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##OutLat done_o)
    else $error("result strobe missing after transfer");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, OutLat)) |-> $past(accept, OutLat))
    else $error("result strobe without a matching transfer");

  a_zero_step_passes_from: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cnt_m == '0)) |-> ##OutLat (color_out_o == $past(color_from_i, OutLat)))
    else $error("zero step count did not return the start color");

  a_end_step_passes_to: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cnt_m != '0) && (cnt_m >= len_m))
      |-> ##OutLat (color_out_o == $past(color_to_i, OutLat)))
    else $error("step count at fade length did not return the end color");

endmodule
